### hdl/vad_pkg.sv
// ---------------------------------------------------------------------------
// vad_pkg
// Shared types and constants of the vibration activity detector.
// ---------------------------------------------------------------------------
package vad_pkg;

  // sample format
  localparam int SAMPLE_BITS = 16;
  localparam int ABS_W       = SAMPLE_BITS + 1;
  localparam int SQ_W        = 2 * ABS_W + 2;
  localparam int ROOT_STEPS  = SQ_W / 2;
  localparam int MAG_W       = ROOT_STEPS;
  localparam int ROOT_REM_W  = MAG_W + 2;

  // window accumulation
  localparam int MAX_SAMPLES = 255;
  localparam int SUM_W       = 24;
  localparam int COUNT_W     = 8;
  localparam int COUNT_LIMIT = (MAX_SAMPLES < 255) ? MAX_SAMPLES : 255;

  // average and comparison
  localparam int FRAC_BITS   = 4;
  localparam int DIVD_W      = SUM_W + FRAC_BITS;
  localparam int AVG_W       = 20;
  localparam int TOTAL_W     = AVG_W + 1;
  localparam int THR_W       = 10;
  localparam int CMP_W       = 31;
  localparam int DIFF_SCALE  = 2000;
  localparam int STEP_W      = 5;

  // configuration
  localparam int PADDR_W                  = 3;
  localparam int PDATA_W                  = 32;
  localparam logic [PADDR_W-1:0] ADDR_THRESHOLD = 3'd0;
  localparam logic [THR_W-1:0]   THRESHOLD_RESET = 10'd10;

  // operation codes
  localparam logic OP_SAMPLE   = 1'b0;
  localparam logic OP_EVALUATE = 1'b1;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

  // classified word as it waits in the queue
  typedef struct packed {
    logic             op;
    logic [ABS_W-1:0] ax;
    logic [ABS_W-1:0] ay;
    logic [ABS_W-1:0] az;
  } vad_entry_t;

  // queue head as seen by the back end
  typedef struct packed {
    logic       valid;
    vad_entry_t entry;
  } vad_head_t;

endpackage

### hdl/vad_if.sv
// ---------------------------------------------------------------------------
// vad_if
// Handshake channels for sample words and result words.
// ---------------------------------------------------------------------------
interface vad_sample_if
  import vad_pkg::*;
  ();
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic signed [SAMPLE_BITS-1:0] acc_x;
  logic signed [SAMPLE_BITS-1:0] acc_y;
  logic signed [SAMPLE_BITS-1:0] acc_z;

  modport source (output valid, op, acc_x, acc_y, acc_z, input ready);
  modport sink (input valid, op, acc_x, acc_y, acc_z, output ready);
endinterface

interface vad_result_if
  import vad_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic               machine_on;
  logic [AVG_W-1:0]   window_average;
  logic [COUNT_W-1:0] window_count;

  modport source (output valid, machine_on, window_average, window_count, input ready);
  modport sink (input valid, machine_on, window_average, window_count, output ready);
endinterface

### hdl/vad_front.sv
// ---------------------------------------------------------------------------
// vad_front
// Accepts sample words, classifies them and folds each axis to its magnitude.
// ---------------------------------------------------------------------------
module vad_front
  import vad_pkg::*;
(
  vad_sample_if.sink samples,
  input  logic       push_ready,
  output logic       push_valid,
  output vad_entry_t push_entry
);

  // two's complement to unsigned magnitude, one bit wider
  function automatic logic [ABS_W-1:0] fold_abs(input logic signed [SAMPLE_BITS-1:0] v);
    logic [ABS_W-1:0] ext;
    ext = {v[SAMPLE_BITS-1], v};
    return v[SAMPLE_BITS-1] ? (ABS_W'(0) - ext) : ext;
  endfunction

  // handshake straight onto the queue
  assign samples.ready = push_ready;
  assign push_valid    = samples.valid;

  // classify and fold
  always_comb begin
    push_entry.op = samples.op;
    push_entry.ax = fold_abs(samples.acc_x);
    push_entry.ay = fold_abs(samples.acc_y);
    push_entry.az = fold_abs(samples.acc_z);
  end

endmodule

### hdl/vad_queue.sv
// ---------------------------------------------------------------------------
// vad_queue
// Short first-in first-out queue between the front and the back end.
// ---------------------------------------------------------------------------
module vad_queue
  import vad_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push_valid,
  input  vad_entry_t push_entry,
  output logic       push_ready,
  input  logic       pop,
  output vad_head_t  head
);

  vad_entry_t         slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QFILL_W-1:0] fill;
  logic               do_push;
  logic               do_pop;

  assign push_ready = (fill != QFILL_W'(QUEUE_DEPTH));
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && (fill != '0);

  assign head.valid = (fill != '0);
  assign head.entry = slots[rd_ptr];

  // pointer advance with wrap
  function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

### hdl/vad_back.sv
// ---------------------------------------------------------------------------
// vad_back
// Sequencer that squares, roots, accumulates, divides and compares.
// ---------------------------------------------------------------------------
module vad_back
  import vad_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  vad_head_t        head,
  output logic             pop,
  input  logic [THR_W-1:0] threshold,
  vad_result_if.source     results
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SQUARE = 3'd1;
  localparam logic [2:0] S_ROOT   = 3'd2;
  localparam logic [2:0] S_ACCUM  = 3'd3;
  localparam logic [2:0] S_DIVIDE = 3'd4;
  localparam logic [2:0] S_SCALE  = 3'd5;
  localparam logic [2:0] S_WEIGH  = 3'd6;
  localparam logic [2:0] S_REPORT = 3'd7;

  logic [2:0]            state;
  logic [STEP_W-1:0]     step;
  vad_entry_t            cur;

  // root datapath
  logic [SQ_W-1:0]       sum_sq;
  logic [SQ_W-1:0]       rad;
  logic [ROOT_REM_W-1:0] root_rem;
  logic [MAG_W-1:0]      root;

  // window state
  logic [SUM_W-1:0]      magnitude_sum;
  logic [COUNT_W-1:0]    sample_count;
  logic [AVG_W-1:0]      baseline_average;
  logic                  baseline_taken;

  // divide and compare datapath
  logic [DIVD_W-1:0]     quot;
  logic [COUNT_W-1:0]    div_rem;
  logic [COUNT_W-1:0]    div_count;
  logic [AVG_W-1:0]      avg_r;
  logic [CMP_W-1:0]      prod_diff;
  logic [CMP_W-1:0]      prod_total;

  // result register
  logic                  res_valid;
  logic                  res_on;
  logic [AVG_W-1:0]      res_avg;
  logic [COUNT_W-1:0]    res_count;

  // combinational helpers
  logic [ABS_W-1:0]      sq_op;
  logic [2*ABS_W-1:0]    sq_raw;
  logic [SQ_W-1:0]       sq_prod;
  logic [ROOT_REM_W+1:0] rem_sh;
  logic [ROOT_REM_W+1:0] trial;
  logic [SUM_W:0]        sum_ext;
  logic [COUNT_W:0]      div_trial;
  logic [AVG_W-1:0]      avg_sat;
  logic [AVG_W-1:0]      diff;
  logic [TOTAL_W-1:0]    total_r;
  logic                  window_full;
  logic                  res_free;

  assign window_full = (sample_count >= COUNT_W'(COUNT_LIMIT));
  assign res_free    = !res_valid || results.ready;
  assign pop         = (state == S_IDLE) && head.valid;

  // one axis squared per cycle
  always_comb begin
    unique case (step[1:0])
      2'd0:    sq_op = cur.ax;
      2'd1:    sq_op = cur.ay;
      2'd2:    sq_op = cur.az;
      default: sq_op = '0;
    endcase
    sq_raw  = sq_op * sq_op;
    sq_prod = SQ_W'(sq_raw);
  end

  // one root digit per cycle
  assign rem_sh = {root_rem, rad[SQ_W-1 -: 2]};
  assign trial  = (ROOT_REM_W+2)'({root, 2'b01});

  // saturating window add
  assign sum_ext = {1'b0, magnitude_sum} + (SUM_W+1)'(root);

  // one quotient bit per cycle
  assign div_trial = {div_rem, quot[DIVD_W-1]};

  // average with saturation, distance and total
  assign avg_sat = (|quot[DIVD_W-1:AVG_W]) ? {AVG_W{1'b1}} : quot[AVG_W-1:0];
  assign diff    = (avg_sat >= baseline_average) ? (avg_sat - baseline_average)
                                                 : (baseline_average - avg_sat);
  assign total_r = TOTAL_W'(avg_r) + TOTAL_W'(baseline_average);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      step             <= '0;
      magnitude_sum    <= '0;
      sample_count     <= '0;
      baseline_average <= '0;
      baseline_taken   <= 1'b0;
      res_valid        <= 1'b0;
    end else begin
      // result word leaves unless a new one is loaded this cycle
      if (results.ready && (state != S_REPORT)) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (head.valid) begin
            cur  <= head.entry;
            step <= '0;
            if (head.entry.op == OP_EVALUATE) begin
              div_count     <= sample_count;
              div_rem       <= '0;
              quot          <= (sample_count == '0) ? '0 : {magnitude_sum, FRAC_BITS'(0)};
              magnitude_sum <= '0;
              sample_count  <= '0;
              state         <= (sample_count == '0) ? S_SCALE : S_DIVIDE;
            end else if (!window_full) begin
              sum_sq <= '0;
              state  <= S_SQUARE;
            end
          end
        end
        S_SQUARE: begin
          sum_sq <= sum_sq + sq_prod;
          if (step == STEP_W'(2)) begin
            step  <= '0;
            state <= S_ROOT;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_ROOT: begin
          if (step == '0) begin
            rad      <= sum_sq;
            root_rem <= '0;
            root     <= '0;
            step     <= step + 1'b1;
          end else begin
            rad <= {rad[SQ_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
              root_rem <= ROOT_REM_W'(rem_sh - trial);
              root     <= {root[MAG_W-2:0], 1'b1};
            end else begin
              root_rem <= ROOT_REM_W'(rem_sh);
              root     <= {root[MAG_W-2:0], 1'b0};
            end
            step <= step + 1'b1;
            if (step == STEP_W'(ROOT_STEPS)) begin
              state <= S_ACCUM;
            end
          end
        end
        S_ACCUM: begin
          magnitude_sum <= sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
          sample_count  <= sample_count + 1'b1;
          state         <= S_IDLE;
        end
        S_DIVIDE: begin
          if (div_trial >= {1'b0, div_count}) begin
            div_rem <= COUNT_W'(div_trial - {1'b0, div_count});
            quot    <= {quot[DIVD_W-2:0], 1'b1};
          end else begin
            div_rem <= div_trial[COUNT_W-1:0];
            quot    <= {quot[DIVD_W-2:0], 1'b0};
          end
          step <= step + 1'b1;
          if (step == STEP_W'(DIVD_W - 1)) begin
            state <= S_SCALE;
          end
        end
        S_SCALE: begin
          if (!baseline_taken) begin
            baseline_average <= avg_sat;
            baseline_taken   <= 1'b1;
            state            <= S_IDLE;
          end else begin
            avg_r     <= avg_sat;
            prod_diff <= CMP_W'(DIFF_SCALE) * CMP_W'(diff);
            state     <= S_WEIGH;
          end
        end
        S_WEIGH: begin
          prod_total <= CMP_W'(threshold) * CMP_W'(total_r);
          state      <= S_REPORT;
        end
        S_REPORT: begin
          if (res_free) begin
            res_valid <= 1'b1;
            res_on    <= (total_r != '0) && (prod_diff >= prod_total);
            res_avg   <= avg_r;
            res_count <= div_count;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign results.valid          = res_valid;
  assign results.machine_on     = res_on;
  assign results.window_average = res_avg;
  assign results.window_count   = res_count;

  // window count never passes its limit
  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    sample_count <= COUNT_W'(COUNT_LIMIT))
    else $error("sample count past limit");

  // the baseline, once taken, stays taken
  a_baseline_sticky: assert property (@(posedge clk) disable iff (rst)
    baseline_taken |=> baseline_taken)
    else $error("baseline lost");

  // no result before a baseline exists
  a_result_after_baseline: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> baseline_taken)
    else $error("result before baseline");

  // divider remainder stays below the divisor
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIVIDE) |-> (div_rem < div_count))
    else $error("divider remainder out of range");

endmodule

### hdl/vibration_activity_detector.sv
// ---------------------------------------------------------------------------
// vibration_activity_detector
// Window magnitude averaging with a baseline-relative activity decision.
// ---------------------------------------------------------------------------
// Sample words (op = 0) add the floor root of x*x + y*y + z*z to the window;
// evaluate words (op = 1) close it and, after the first one that sets the
// baseline, give one result word. A sample is popped, squared axis by axis
// on the shared squarer, rooted digit by digit and then accumulated; a
// sample that arrives on a full window is dropped. An evaluate runs the
// 28-step restoring divider, two multiplies and the hand-over to the
// result register. A two-word queue lets samples be taken while the back
// end is busy or a result waits. The threshold register sits at byte
// address 0 and is written over APB.
// ---------------------------------------------------------------------------
module vibration_activity_detector
  import vad_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  vad_sample_if.sink         samples,
  vad_result_if.source       results,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic [THR_W-1:0] threshold;
  logic             push_valid;
  logic             push_ready;
  vad_entry_t       push_entry;
  logic             pop;
  vad_head_t        head;

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_THRESHOLD) ? PDATA_W'(threshold) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RESET;
    end else if (psel && penable && pwrite && pready && (paddr == ADDR_THRESHOLD)) begin
      threshold <= pwdata[THR_W-1:0];
    end
  end

  // front end
  vad_front u_front (
    .samples    (samples),
    .push_ready (push_ready),
    .push_valid (push_valid),
    .push_entry (push_entry)
  );

  // queue
  vad_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .push_ready (push_ready),
    .pop        (pop),
    .head       (head)
  );

  // back end
  vad_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .threshold (threshold),
    .results   (results)
  );

endmodule
